FILE: rtl/utf8_text_glyph_renderer_macros.svh
// assertion macros for the utf8 text glyph renderer
`ifndef UTF8_TEXT_GLYPH_RENDERER_MACROS_SVH
`define UTF8_TEXT_GLYPH_RENDERER_MACROS_SVH

// checked on every clock edge outside reset
`define UTGR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define UTGR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/utgr_pkg.sv
// shared types, constants, font rom and codepoint mapping of the glyph renderer
package utgr_pkg;

  localparam int ScreenColumnsDefault = 80;
  localparam int ScreenRowsDefault    = 25;

  localparam int AddrW     = 11;
  localparam int PenW      = 16;
  localparam int CodeW     = 16;
  localparam int GlyphW    = 7;
  localparam int GlyphCols = 5;
  localparam int GlyphRows = 7;
  localparam int PixelCnt  = GlyphCols * GlyphRows;
  localparam int PixIdxW   = $clog2(PixelCnt);

  localparam logic [7:0]        BlockCode      = 8'hDB;
  localparam logic [PenW-1:0]   PenStep        = 16'd6;
  localparam logic [PenW-1:0]   PenMax         = 16'h7FFF;
  localparam logic [GlyphW-1:0] SpaceGlyph     = 7'd26;
  localparam logic [GlyphW-1:0] CyrBase        = 7'd45;
  localparam logic [CodeW-1:0]  CyrUpperFirst  = 16'h0410;
  localparam logic [CodeW-1:0]  CyrLowerFirst  = 16'h0430;
  localparam logic [CodeW-1:0]  CyrLowerLast   = 16'h044F;
  localparam logic [CodeW-1:0]  SpaceCode      = 16'h0020;

  localparam logic [7:0] StartColumnReset = 8'd0;
  localparam logic [5:0] TextRowReset     = 6'd0;
  localparam logic [7:0] ColourReset      = 8'd10;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_START_COLUMN     = 2'd0,
    CFG_TEXT_ROW         = 2'd1,
    CFG_COLOUR_ATTRIBUTE = 2'd2
  } cfg_index_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_PREP = 2'd1,
    ST_SCAN = 2'd2
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic prep;
    logic step;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic draw;
    logic prep_empty;
    logic cur_set;
    logic out_free;
    logic last;
  } status_t;

  // font rom, columns left to right from the high byte down, bit 0 is the top row
  function automatic logic [GlyphCols*8-1:0] glyph_bits(input logic [GlyphW-1:0] g);
    logic [GlyphCols*8-1:0] v;
    begin
      unique case (g)
        7'd0:  v = 40'h7E1111117E;
        7'd1:  v = 40'h7F49494936;
        7'd2:  v = 40'h3E41414122;
        7'd3:  v = 40'h7F4141221C;
        7'd4:  v = 40'h7F49494941;
        7'd5:  v = 40'h7F09090901;
        7'd6:  v = 40'h3E4149497A;
        7'd7:  v = 40'h7F0808087F;
        7'd8:  v = 40'h00417F4100;
        7'd9:  v = 40'h2040413F01;
        7'd10: v = 40'h7F08142241;
        7'd11: v = 40'h7F40404040;
        7'd12: v = 40'h7F0204027F;
        7'd13: v = 40'h7F0408107F;
        7'd14: v = 40'h3E4141413E;
        7'd15: v = 40'h7F09090906;
        7'd16: v = 40'h3E4151215E;
        7'd17: v = 40'h7F09192946;
        7'd18: v = 40'h4649494931;
        7'd19: v = 40'h01017F0101;
        7'd20: v = 40'h3F4040403F;
        7'd21: v = 40'h1F2040201F;
        7'd22: v = 40'h7F2010207F;
        7'd23: v = 40'h6314081463;
        7'd24: v = 40'h0708700807;
        7'd25: v = 40'h6151494543;
        7'd26: v = 40'h0000000000;
        7'd27: v = 40'h3E4549513E;
        7'd28: v = 40'h00427F4000;
        7'd29: v = 40'h2143454931;
        7'd30: v = 40'h4241516946;
        7'd31: v = 40'h1814127F10;
        7'd32: v = 40'h4F49494931;
        7'd33: v = 40'h3E49494930;
        7'd34: v = 40'h0171090503;
        7'd35: v = 40'h3649494936;
        7'd36: v = 40'h064949291E;
        7'd37: v = 40'h0024002400;
        7'd38: v = 40'h00007E0000;
        7'd39: v = 40'h00005F0000;
        7'd40: v = 40'h242A7F2A12;
        7'd41: v = 40'h147F147F14;
        7'd42: v = 40'h0000606000;
        7'd43: v = 40'h0080606000;
        7'd44: v = 40'h0201590906;
        7'd45: v = 40'h7E1111117E;
        7'd46: v = 40'h3E49494930;
        7'd47: v = 40'h7F49494936;
        7'd48: v = 40'h7F01010101;
        7'd49: v = 40'h7E111111FF;
        7'd50: v = 40'h7F49494941;
        7'd51: v = 40'h49361C3649;
        7'd52: v = 40'h2241494936;
        7'd53: v = 40'h7F0204087F;
        7'd54: v = 40'h5E0102047E;
        7'd55: v = 40'h7F08142241;
        7'd56: v = 40'h7E1111117E;
        7'd57: v = 40'h7F0204027F;
        7'd58: v = 40'h7F0808087F;
        7'd59: v = 40'h3E4141413E;
        7'd60: v = 40'h7E4141417E;
        7'd61: v = 40'h7F09090906;
        7'd62: v = 40'h3E41414122;
        7'd63: v = 40'h01017F0101;
        7'd64: v = 40'h0608700806;
        7'd65: v = 40'h1C3E7F3E1C;
        7'd66: v = 40'h6314081463;
        7'd67: v = 40'h3E414141FE;
        7'd68: v = 40'h3E4141413C;
        7'd69: v = 40'h7F4040407F;
        7'd70: v = 40'h7F404040FF;
        7'd71: v = 40'h7F49494941;
        7'd72: v = 40'h7F404A4936;
        7'd73: v = 40'h7F40404020;
        7'd74: v = 40'h224949493E;
        7'd75: v = 40'h7E097E497E;
        7'd76: v = 40'h7E1131117E;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

  // codepoint to font index, lowercase folds to uppercase, unknown is a space
  function automatic logic [GlyphW-1:0] glyph_of(input logic [CodeW-1:0] cp);
    logic [GlyphW-1:0] g;
    begin
      g = SpaceGlyph;
      priority if (cp >= 16'h0041 && cp <= 16'h005A) begin
        g = GlyphW'(cp - 16'h0041);
      end else if (cp >= 16'h0061 && cp <= 16'h007A) begin
        g = GlyphW'(cp - 16'h0061);
      end else if (cp >= 16'h0030 && cp <= 16'h0039) begin
        g = GlyphW'(cp - 16'h0030) + 7'd27;
      end else if (cp == 16'h003A) begin
        g = 7'd37;
      end else if (cp == 16'h007C) begin
        g = 7'd38;
      end else if (cp == 16'h0021) begin
        g = 7'd39;
      end else if (cp == 16'h0024) begin
        g = 7'd40;
      end else if (cp == 16'h0023) begin
        g = 7'd41;
      end else if (cp == 16'h002E) begin
        g = 7'd42;
      end else if (cp == 16'h002C) begin
        g = 7'd43;
      end else if (cp == 16'h003F) begin
        g = 7'd44;
      end else if (cp >= CyrUpperFirst && cp < CyrLowerFirst) begin
        g = CyrBase + GlyphW'(cp - CyrUpperFirst);
      end else if (cp >= CyrLowerFirst && cp <= CyrLowerLast) begin
        g = CyrBase + GlyphW'(cp - CyrLowerFirst);
      end else begin
        g = SpaceGlyph;
      end
      return g;
    end
  endfunction

endpackage

FILE: rtl/utgr_ctrl.sv
// controller state machine: take a byte, prepare the glyph mask, scan the pixels
module utgr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  utgr_pkg::status_t status_i,
  output utgr_pkg::cmd_t    cmd_o
);

  utgr_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= utgr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      utgr_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (status_i.draw) begin
            state_d = utgr_pkg::ST_PREP;
          end
        end
      end
      utgr_pkg::ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = status_i.prep_empty ? utgr_pkg::ST_IDLE : utgr_pkg::ST_SCAN;
      end
      utgr_pkg::ST_SCAN: begin
        // unlit or clipped pixels are skipped, lit ones wait for the output register
        if (!status_i.cur_set) begin
          cmd_o.step = 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.step = 1'b1;
          cmd_o.emit = 1'b1;
          if (status_i.last) begin
            state_d = utgr_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = utgr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/utgr_datapath.sv
// datapath: utf-8 decoder, pen, configuration, pixel mask, scan counters, output register
module utgr_datapath #(
  parameter int SCREEN_COLUMNS = utgr_pkg::ScreenColumnsDefault,
  parameter int SCREEN_ROWS    = utgr_pkg::ScreenRowsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  utgr_pkg::cmd_t              cmd_i,
  output utgr_pkg::status_t           status_o,
  input  logic [7:0]                  text_byte_i,
  input  logic                        new_text_i,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [7:0]                  cfg_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [utgr_pkg::AddrW-1:0]  cell_address_o,
  output logic [15:0]                 cell_word_o,
  output logic                        last_write_o
);

  localparam int PenW   = utgr_pkg::PenW;
  localparam int CodeW  = utgr_pkg::CodeW;
  localparam int Pixels = utgr_pkg::PixelCnt;

  // configuration
  logic signed [7:0] start_col_q;
  logic signed [5:0] text_row_q;
  logic [7:0]        colour_q;

  // decoder and pen state
  logic signed [PenW-1:0]      pen_q, pen_d;
  logic [1:0]                  pend_q, pend_d;
  logic [CodeW-1:0]            part_q, part_d;
  logic [utgr_pkg::GlyphW-1:0] glyph_q;
  logic signed [PenW-1:0]      col_q;

  // scan state
  logic [Pixels-1:0] mask_q, mask_d, mask_clr;
  logic [2:0]        c_q, r_q;
  logic              out_valid_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_col_q <= utgr_pkg::StartColumnReset;
      text_row_q  <= utgr_pkg::TextRowReset;
      colour_q    <= utgr_pkg::ColourReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        utgr_pkg::CFG_START_COLUMN:     start_col_q <= cfg_data_i;
        utgr_pkg::CFG_TEXT_ROW:         text_row_q  <= cfg_data_i[5:0];
        utgr_pkg::CFG_COLOUR_ATTRIBUTE: colour_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // utf-8 decode of the offered byte
  logic [1:0]             pend0;
  logic [CodeW-1:0]       part0;
  logic signed [PenW-1:0] pen0;
  logic [CodeW-1:0]       cp;
  logic                   draw;

  always_comb begin
    pend0  = new_text_i ? 2'd0 : pend_q;
    part0  = new_text_i ? '0 : part_q;
    pen0   = new_text_i ? PenW'(start_col_q) : pen_q;
    pend_d = pend0;
    part_d = part0;
    cp     = utgr_pkg::SpaceCode;
    draw   = 1'b0;
    priority if (pend0 != 2'd0) begin
      part_d = {part0[CodeW-7:0], text_byte_i[5:0]};
      pend_d = pend0 - 2'd1;
      draw   = (pend_d == 2'd0);
      cp     = part_d;
    end else if (!text_byte_i[7]) begin
      draw = 1'b1;
      cp   = CodeW'(text_byte_i);
    end else if (text_byte_i[7:5] == 3'b110) begin
      part_d = CodeW'(text_byte_i[4:0]);
      pend_d = 2'd1;
    end else if (text_byte_i[7:4] == 4'b1110) begin
      part_d = CodeW'(text_byte_i[3:0]);
      pend_d = 2'd2;
    end else begin
      draw = 1'b1;
    end
  end

  // visibility mask of the glyph at the current pen
  logic [utgr_pkg::GlyphCols*8-1:0] rom_bits;
  logic [Pixels-1:0]                prep_mask;
  logic signed [PenW:0]             prep_px;
  logic signed [6:0]                prep_py;
  logic [utgr_pkg::GlyphCols-1:0]   col_ok;
  logic [utgr_pkg::GlyphRows-1:0]   row_ok;

  always_comb begin
    rom_bits = utgr_pkg::glyph_bits(glyph_q);
    for (int c = 0; c < utgr_pkg::GlyphCols; c++) begin
      prep_px   = $signed({pen_q[PenW-1], pen_q}) + $signed((PenW+1)'(c));
      col_ok[c] = (int'(prep_px) >= 0) && (int'(prep_px) < SCREEN_COLUMNS);
    end
    for (int r = 0; r < utgr_pkg::GlyphRows; r++) begin
      prep_py   = $signed({text_row_q[5], text_row_q}) + $signed(7'(r));
      row_ok[r] = (int'(prep_py) >= 0) && (int'(prep_py) < SCREEN_ROWS);
    end
    for (int c = 0; c < utgr_pkg::GlyphCols; c++) begin
      for (int r = 0; r < utgr_pkg::GlyphRows; r++) begin
        prep_mask[c*utgr_pkg::GlyphRows + r] =
          rom_bits[8*(utgr_pkg::GlyphCols-1-c) + r] && col_ok[c] && row_ok[r];
      end
    end
  end

  // pen advance with saturation
  logic signed [PenW:0] pen_sum;
  assign pen_sum = $signed({pen_q[PenW-1], pen_q}) + $signed({1'b0, utgr_pkg::PenStep});

  always_comb begin
    pen_d = pen_q;
    if (cmd_i.take) begin
      pen_d = pen0;
    end else if (cmd_i.prep) begin
      pen_d = (pen_sum > $signed({1'b0, utgr_pkg::PenMax})) ? utgr_pkg::PenMax
                                                            : pen_sum[PenW-1:0];
    end
  end

  // current pixel of the scan
  logic [utgr_pkg::PixIdxW-1:0] pix_idx;
  logic                         cur_set;
  logic                         out_free;

  assign pix_idx  = utgr_pkg::PixIdxW'(c_q) * utgr_pkg::PixIdxW'(utgr_pkg::GlyphRows) +
                    utgr_pkg::PixIdxW'(r_q);
  assign cur_set  = mask_q[pix_idx];
  assign mask_clr = mask_q & ~(Pixels'(1) << pix_idx);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    mask_d = mask_q;
    if (cmd_i.prep) begin
      mask_d = prep_mask;
    end else if (cmd_i.step) begin
      mask_d = mask_clr;
    end
  end

  // control state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q       <= '0;
      pend_q      <= '0;
      part_q      <= '0;
      mask_q      <= '0;
      c_q         <= '0;
      r_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pen_q  <= pen_d;
      mask_q <= mask_d;
      if (cmd_i.take) begin
        pend_q <= pend_d;
        part_q <= part_d;
      end
      if (cmd_i.prep) begin
        c_q <= '0;
        r_q <= '0;
      end else if (cmd_i.step) begin
        if (r_q == 3'(utgr_pkg::GlyphRows - 1)) begin
          r_q <= '0;
          c_q <= c_q + 3'd1;
        end else begin
          r_q <= r_q + 3'd1;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // cell address of the current pixel
  logic signed [PenW:0] cur_px;
  logic signed [6:0]    cur_py;
  logic [utgr_pkg::AddrW-1:0] cur_addr;

  always_comb begin
    cur_px   = $signed({col_q[PenW-1], col_q}) + $signed((PenW+1)'(c_q));
    cur_py   = $signed({text_row_q[5], text_row_q}) + $signed(7'(r_q));
    cur_addr = utgr_pkg::AddrW'(int'(cur_py[6:0]) * SCREEN_COLUMNS + int'(cur_px[7:0]));
  end

  // glyph and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && draw) begin
      glyph_q <= utgr_pkg::glyph_of(cp);
    end
    if (cmd_i.prep) begin
      col_q <= pen_q;
    end
    if (cmd_i.emit) begin
      cell_address_o <= cur_addr;
      cell_word_o    <= {colour_q, utgr_pkg::BlockCode};
      last_write_o   <= (mask_clr == '0);
    end
  end

  assign out_valid_o = out_valid_q;

  // status to the controller
  always_comb begin
    status_o            = '0;
    status_o.draw       = draw;
    status_o.prep_empty = (prep_mask == '0);
    status_o.cur_set    = cur_set;
    status_o.out_free   = out_free;
    status_o.last       = (mask_clr == '0);
  end

endmodule

FILE: rtl/utf8_text_glyph_renderer.sv
// UTF-8 text to 5x7 block-glyph text buffer writer, top level
// a lead byte of a multibyte sequence is only taken into the decoder; a byte that
// finishes a glyph is decoded, then the clipped pixel mask is built and, unless it
// is empty, the pixel positions are scanned up to the last visible lit pixel, waiting
// on output stalls; the first cell write is registered at the first lit pixel scanned
// reset clears the decoder, pen, scan and output valid and loads register defaults
module utf8_text_glyph_renderer #(
  parameter int SCREEN_COLUMNS = utgr_pkg::ScreenColumnsDefault,
  parameter int SCREEN_ROWS    = utgr_pkg::ScreenRowsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [7:0]                  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  text_byte_i,
  input  logic                        new_text_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [utgr_pkg::AddrW-1:0]  cell_address_o,
  output logic [15:0]                 cell_word_o,
  output logic                        last_write_o
);

  `include "utf8_text_glyph_renderer_macros.svh"

  utgr_pkg::cmd_t    cmd;
  utgr_pkg::status_t status;

  // controller
  utgr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath
  utgr_datapath #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .text_byte_i    (text_byte_i),
    .new_text_i     (new_text_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cell_address_o (cell_address_o),
    .cell_word_o    (cell_word_o),
    .last_write_o   (last_write_o)
  );

  // assertions
  `UTGR_ASSERT(a_emit_while_busy, cmd.emit |-> in_stall_o, "cell write loaded while idle")
  `UTGR_ASSERT(a_mid_glyph, (out_valid_o && !last_write_o) |-> in_stall_o, "ready mid glyph")
  `UTGR_ASSERT(a_step_on_emit, cmd.emit |-> (cmd.step && status.cur_set), "write without a lit pixel")
  `UTGR_ASSERT_ALWAYS(a_idle_after_reset, !rst_ni |=> !in_stall_o, "not ready after reset")

endmodule
